// ===== hw/rtl/mts_pkg.sv =====
package mts_pkg;

	// Operation codes carried by the opcode field
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Shift control broadcast to every cell of the chain
	typedef struct packed {
		logic shift_dn;   // push: each cell takes the entry from above
		logic shift_up;   // pop: each cell takes the entry from below
	} shift_ctrl_t;

endpackage

// ===== hw/rtl/mts_if.sv =====
// Command channel: one push or pop per item
interface mts_cmd_if #(parameter int VALUE_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic signed [VALUE_WIDTH-1:0] push_value;

	modport source (output valid, output opcode, output push_value, input ready);
	modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

// Result channel: one result item per command item
interface mts_res_if #(parameter int VALUE_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] popped_value;
	logic signed [VALUE_WIDTH-1:0] top_value;
	logic signed [VALUE_WIDTH-1:0] min_value;
	logic                          stack_empty;
	logic                          underflow_error;
	logic                          overflow_error;

	modport source (output valid, output popped_value, output top_value, output min_value,
		output stack_empty, output underflow_error, output overflow_error, input ready);
	modport sink   (input valid, input popped_value, input top_value, input min_value,
		input stack_empty, input underflow_error, input overflow_error, output ready);
endinterface

// ===== hw/rtl/mts_cell.sv =====
module mts_cell #(
	parameter int EntryWidth = 34
) (
	input  logic                    clk,
	input  mts_pkg::shift_ctrl_t    ctrl,
	input  logic [EntryWidth-1:0]   from_above,
	input  logic [EntryWidth-1:0]   from_below,
	output logic [EntryWidth-1:0]   data
);
	import mts_pkg::*;

	logic [EntryWidth-1:0] data_q;

	// Shift down on push, up on pop, otherwise hold
	always_ff @(posedge clk) begin
		if (ctrl.shift_dn) begin
			data_q <= from_above;
		end else if (ctrl.shift_up) begin
			data_q <= from_below;
		end
	end

	assign data = data_q;

endmodule

// ===== hw/rtl/min_tracking_stack.sv =====
// Results are registered in the result register or the skid stage. Throughput:
// one item per cycle while the skid stage is empty; the top cell of the shift
// chain and the minimum register are updated in the same cycle the item is
// accepted. A two-deep result buffer lets one more item in while a result
// waits. Reset clears the entry count, the minimum (to the largest positive
// value) and the result valid flags; the chain cells are not reset.
module min_tracking_stack #(
	parameter int STACK_DEPTH = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	mts_cmd_if.sink   cmd,
	mts_res_if.source res
);
	import mts_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int EW = VALUE_WIDTH + 2;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef struct packed {
		logic signed [W-1:0] popped;
		logic signed [W-1:0] top;
		logic signed [W-1:0] minv;
		logic                empty;
		logic                underflow;
		logic                overflow;
	} result_t;

	logic [CW-1:0]       cnt_q;
	logic signed [W-1:0] min_q;
	logic                out_valid_q;
	logic                skid_valid_q;
	result_t             out_q;
	result_t             skid_q;

	logic [EW-1:0]        cell_data [STACK_DEPTH];
	shift_ctrl_t          ctrl;
	logic                 accept;
	logic                 take;
	logic                 is_empty;
	logic                 is_full;
	logic signed [EW-1:0] v_x;
	logic signed [EW-1:0] min_x;
	logic signed [EW-1:0] top_x;
	logic signed [EW-1:0] next_x;
	logic signed [EW-1:0] enc_word;
	logic signed [EW-1:0] restore_x;
	logic signed [W-1:0]  min_nxt;
	logic [CW-1:0]        cnt_nxt;
	logic signed [W-1:0]  neg_one;
	result_t              res_nxt;

	assign accept   = cmd.valid && cmd.ready;
	assign take     = out_valid_q && res.ready;
	assign cmd.ready = !skid_valid_q;
	assign is_empty = (cnt_q == '0);
	assign is_full  = (cnt_q == CW'(STACK_DEPTH));
	assign neg_one  = {W{1'b1}};

	// Sign-extend operands into the entry width
	assign v_x     = {{2{cmd.push_value[W-1]}}, cmd.push_value};
	assign min_x   = {{2{min_q[W-1]}}, min_q};
	assign top_x   = cell_data[0];
	assign next_x  = cell_data[1];

	// Encode on a new minimum: 2*value - min sits below the new minimum
	always_comb begin
		if (is_empty) begin
			enc_word = v_x;
		end else if (v_x < min_x) begin
			enc_word = (v_x <<< 1) - min_x;
		end else begin
			enc_word = v_x;
		end
	end

	// Recover the previous minimum from an encoded top: 2*min - entry
	assign restore_x = (min_x <<< 1) - top_x;

	// Step the stack: work out the next count, minimum and result item
	always_comb begin
		ctrl           = '0;
		cnt_nxt        = cnt_q;
		min_nxt        = min_q;
		res_nxt.popped = neg_one;
		res_nxt.top    = neg_one;
		res_nxt.minv   = neg_one;
		res_nxt.empty  = is_empty;
		res_nxt.underflow = 1'b0;
		res_nxt.overflow  = 1'b0;
		case (cmd.opcode)
			OP_PUSH: begin
				if (is_full) begin
					res_nxt.overflow = 1'b1;
					res_nxt.top  = (top_x < min_x) ? min_q : top_x[W-1:0];
					res_nxt.minv = min_q;
				end else begin
					ctrl.shift_dn = 1'b1;
					cnt_nxt       = cnt_q + CW'(1);
					if (is_empty || (v_x < min_x)) begin
						min_nxt = cmd.push_value;
					end
					res_nxt.top   = cmd.push_value;
					res_nxt.minv  = min_nxt;
					res_nxt.empty = 1'b0;
				end
			end
			OP_POP: begin
				if (is_empty) begin
					res_nxt.underflow = 1'b1;
				end else begin
					ctrl.shift_up = 1'b1;
					cnt_nxt       = cnt_q - CW'(1);
					if (top_x > min_x) begin
						res_nxt.popped = top_x[W-1:0];
					end else begin
						res_nxt.popped = min_q;
						min_nxt        = restore_x[W-1:0];
					end
					res_nxt.empty = (cnt_nxt == '0);
					if (cnt_nxt != '0) begin
						res_nxt.top  = (next_x < $signed({{2{min_nxt[W-1]}}, min_nxt})) ?
							min_nxt : next_x[W-1:0];
						res_nxt.minv = min_nxt;
					end
				end
			end
			default: begin
				ctrl = '0;
			end
		endcase
		if (!accept) begin
			ctrl = '0;
		end
	end

	// Row of cells: the top of the stack always lives in the first cell
	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			logic [EW-1:0] above;
			logic [EW-1:0] below;
			if (gi == 0) begin : g_first
				assign above = enc_word;
			end else begin : g_inner
				assign above = cell_data[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_last
				assign below = cell_data[gi];
			end else begin : g_rest
				assign below = cell_data[gi+1];
			end
			mts_cell #(
				.EntryWidth(EW)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.from_above(above),
				.from_below(below),
				.data      (cell_data[gi])
			);
		end
	endgenerate

	// Hold the count and the minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			min_q <= {1'b0, {(W-1){1'b1}}};
		end else if (accept) begin
			cnt_q <= cnt_nxt;
			min_q <= min_nxt;
		end
	end

	// Result register with a skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (!out_valid_q || take) begin
				out_q <= res_nxt;
			end else begin
				skid_q <= res_nxt;
			end
		end
	end

	assign res.valid           = out_valid_q;
	assign res.popped_value    = out_q.popped;
	assign res.top_value       = out_q.top;
	assign res.min_value       = out_q.minv;
	assign res.stack_empty     = out_q.empty;
	assign res.underflow_error = out_q.underflow;
	assign res.overflow_error  = out_q.overflow;

	// The skid stage only fills behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds an item with the result register empty");

	// The count never passes the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("entry count beyond stack depth");

	// A push that fits adds exactly one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd.opcode == OP_PUSH) && !is_full |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("push did not advance the count");

	// An empty result reports no top and no minimum
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.empty |-> (out_q.top == neg_one) && (out_q.minv == neg_one))
		else $error("empty result carries a top or minimum");

	// Underflow and overflow never flag together
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.underflow && out_q.overflow))
		else $error("both error flags raised on one item");

endmodule

// ===== dv/min_tracking_stack_test.sv =====
`timescale 1ns / 100ps

module min_tracking_stack_test;
	import mts_pkg::*;

	localparam int DEPTH = 64;
	localparam int WIDTH = 32;
	localparam logic signed [WIDTH-1:0] VALUE_MAX = 32'sh7fff_ffff;
	localparam logic signed [WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam int ITEMS_PER_PHASE = 260;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD_CYCLES = 120;

	typedef struct {
		logic                    opcode;
		logic signed [WIDTH-1:0] value;
	} stack_cmd_t;

	typedef struct {
		logic signed [WIDTH-1:0] popped;
		logic signed [WIDTH-1:0] top;
		logic signed [WIDTH-1:0] minimum;
		bit                      empty;
		bit                      underflow;
		bit                      overflow;
	} stack_result_t;

	logic clk;
	logic arst_n;

	mts_cmd_if #(.VALUE_WIDTH(WIDTH)) cmd_ch ();
	mts_res_if #(.VALUE_WIDTH(WIDTH)) res_ch ();

	min_tracking_stack #(.STACK_DEPTH(DEPTH), .VALUE_WIDTH(WIDTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.res    (res_ch.source)
	);

	// Commands waiting to be offered, and results owed by the block
	stack_cmd_t    pending_cmds[$];
	stack_result_t results_due[$];

	// Shadow of the stack contents
	logic signed [WIDTH+1:0] shadow_entries[DEPTH];
	int                      shadow_depth;
	longint                  shadow_min;

	int idle_phase;
	int send_idle_pct[3] = '{18, 84, 0};
	int recv_idle_pct[3] = '{84, 18, 0};
	int mismatches;
	int items_accepted;
	int results_checked;
	int overflow_hits;
	int underflow_hits;
	int deepest_fill;
	int stall_cycles;
	int hold_left;
	bit long_hold_done;
	int planned_depth;

	// Advance the shadow stack by one command and return the result it owes
	function automatic stack_result_t min_stack_step(logic op, logic signed [WIDTH-1:0] value);
		stack_result_t r;
		longint        v;
		longint        cur;
		longint        enc;
		longint        popped;
		longint        top;
		longint        restored;
		logic signed [WIDTH-1:0] narrow;
		v = value;
		popped = -1;
		top = -1;
		r.underflow = 1'b0;
		r.overflow = 1'b0;
		if (op == OP_PUSH) begin
			if (shadow_depth >= DEPTH) begin
				r.overflow = 1'b1;
				overflow_hits++;
			end else begin
				if (shadow_depth == 0) begin
					enc = v;
					shadow_min = v;
				end else if (v < shadow_min) begin
					// encode below the new minimum so the old one can be recovered
					enc = 2 * v - shadow_min;
					shadow_min = v;
				end else begin
					enc = v;
				end
				shadow_entries[shadow_depth] = enc[WIDTH+1:0];
				shadow_depth++;
				if (shadow_depth > deepest_fill)
					deepest_fill = shadow_depth;
			end
		end else begin
			if (shadow_depth == 0) begin
				r.underflow = 1'b1;
				underflow_hits++;
			end else begin
				cur = shadow_entries[shadow_depth-1];
				shadow_depth--;
				if (cur > shadow_min) begin
					popped = cur;
				end else begin
					popped = shadow_min;
					restored = 2 * shadow_min - cur;
					narrow = restored[WIDTH-1:0];
					shadow_min = narrow;
				end
			end
		end
		r.minimum = -1;
		if (shadow_depth > 0) begin
			cur = shadow_entries[shadow_depth-1];
			top = (cur < shadow_min) ? shadow_min : cur;
			r.minimum = shadow_min[WIDTH-1:0];
		end
		r.popped = popped[WIDTH-1:0];
		r.top = top[WIDTH-1:0];
		r.empty = (shadow_depth == 0);
		return r;
	endfunction

	// Queue one command, tracking the depth it will leave behind
	task automatic plan_cmd(logic op, logic signed [WIDTH-1:0] value);
		stack_cmd_t c;
		c.opcode = op;
		c.value = value;
		pending_cmds.push_back(c);
		if (op == OP_PUSH)
			planned_depth = (planned_depth < DEPTH) ? planned_depth + 1 : DEPTH;
		else
			planned_depth = (planned_depth > 0) ? planned_depth - 1 : 0;
	endtask

	// Mix extremes, small clustered values and full-range values
	function automatic logic signed [WIDTH-1:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 15) begin
			case ($urandom_range(5))
				0: return VALUE_MIN;
				1: return VALUE_MAX;
				2: return VALUE_MIN + 1;
				3: return VALUE_MAX - 1;
				4: return -1;
				default: return 0;
			endcase
		end
		if (sel < 70)
			return $signed($urandom_range(200)) - 100;
		return $urandom;
	endfunction

	// Build one phase of random traffic with a single fill-and-drain pass
	task automatic plan_random_phase(int count);
		int planned;
		int fill_at;
		int run_len;
		int push_pct;
		int n;
		bit filled;
		planned = 0;
		filled = 1'b0;
		fill_at = $urandom_range(count / 2);
		while (planned < count) begin
			if (!filled && planned >= fill_at) begin
				// push past full, then drain past empty
				n = DEPTH - planned_depth + $urandom_range(3, 1);
				repeat (n) plan_cmd(OP_PUSH, pick_value());
				planned += n;
				n = DEPTH + $urandom_range(2, 1);
				repeat (n) plan_cmd(OP_POP, $urandom);
				planned += n;
				filled = 1'b1;
			end else begin
				run_len = $urandom_range(24, 4);
				case ($urandom_range(2))
					0: push_pct = 75;
					1: push_pct = 50;
					default: push_pct = 25;
				endcase
				repeat (run_len) begin
					if ($urandom_range(99) < push_pct)
						plan_cmd(OP_PUSH, pick_value());
					else
						plan_cmd(OP_POP, $urandom);
				end
				planned += run_len;
			end
		end
	endtask

	task automatic check_field(string field, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || cmd_ch.valid || results_due.size() != 0)
			@(posedge clk);
	endtask

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Driver: offer pending commands, predicting each one as it is taken
	always @(posedge clk or negedge arst_n) begin : drive_cmds
		stack_cmd_t next_cmd;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.opcode <= OP_PUSH;
			cmd_ch.push_value <= '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				results_due.push_back(min_stack_step(cmd_ch.opcode, cmd_ch.push_value));
				items_accepted++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (pending_cmds.size() != 0 &&
				    $urandom_range(99) >= send_idle_pct[idle_phase]) begin
					next_cmd = pending_cmds.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.opcode <= next_cmd.opcode;
					cmd_ch.push_value <= next_cmd.value;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result against the oldest prediction, and pace ready
	always @(posedge clk or negedge arst_n) begin : watch_results
		stack_result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: result item with no command outstanding", $time);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("popped_value", want.popped, res_ch.popped_value);
					check_field("top_value", want.top, res_ch.top_value);
					check_field("min_value", want.minimum, res_ch.min_value);
					check_field("stack_empty", want.empty, res_ch.stack_empty);
					check_field("underflow_error", want.underflow, res_ch.underflow_error);
					check_field("overflow_error", want.overflow, res_ch.overflow_error);
					results_checked++;
				end
			end
			// hold ready low for a long stretch once, so the input backs up
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (idle_phase == 2 && !long_hold_done) begin
				res_ch.ready <= 1'b0;
				hold_left <= LONG_HOLD_CYCLES;
				long_hold_done <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct[idle_phase]);
			end
		end
	end

	// Watchdog: give up when outstanding work stops moving
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
		    (pending_cmds.size() == 0 && !cmd_ch.valid && results_due.size() == 0)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("min_tracking_stack regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Sequence: reset, directed cases, then three phases of random traffic
	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_PUSH;
		cmd_ch.push_value = '0;
		res_ch.ready = 1'b0;
		idle_phase = 0;
		mismatches = 0;
		items_accepted = 0;
		results_checked = 0;
		overflow_hits = 0;
		underflow_hits = 0;
		deepest_fill = 0;
		stall_cycles = 0;
		planned_depth = 0;
		shadow_depth = 0;
		shadow_min = VALUE_MAX;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty pop, extremes, equal minimum, drain to empty
		plan_cmd(OP_POP, VALUE_MIN);
		plan_cmd(OP_PUSH, VALUE_MAX);
		plan_cmd(OP_PUSH, 0);
		plan_cmd(OP_PUSH, VALUE_MIN);
		plan_cmd(OP_PUSH, VALUE_MIN);
		plan_cmd(OP_PUSH, VALUE_MAX);
		plan_cmd(OP_PUSH, -1);
		repeat (6) plan_cmd(OP_POP, VALUE_MAX);
		plan_cmd(OP_POP, -1);
		// stale minimum replaced by the first push after empty
		plan_cmd(OP_PUSH, -5);
		plan_cmd(OP_PUSH, 7);
		plan_cmd(OP_PUSH, -6);
		plan_cmd(OP_PUSH, -6);
		plan_cmd(OP_PUSH, VALUE_MIN + 1);
		repeat (5) plan_cmd(OP_POP, 0);

		for (int p = 0; p < 3; p++) begin
			@(posedge clk);
			idle_phase <= p;
			plan_random_phase(ITEMS_PER_PHASE);
			wait_drained();
		end
		repeat (8) @(posedge clk);

		$display("checked %0d results from %0d commands, deepest fill %0d of %0d",
			results_checked, items_accepted, deepest_fill, DEPTH);
		$display("pushes dropped on full stack: %0d, pops on empty stack: %0d",
			overflow_hits, underflow_hits);
		if (mismatches == 0 && results_due.size() == 0)
			$display("min_tracking_stack regression: pass");
		else
			$display("min_tracking_stack regression: fail");
		$finish;
	end

endmodule

// ===== min_tracking_stack.f =====
hw/rtl/mts_pkg.sv
hw/rtl/mts_if.sv
hw/rtl/mts_cell.sv
hw/rtl/min_tracking_stack.sv
dv/min_tracking_stack_test.sv
